// File: rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Types, constants and the node merge function shared by the top-two range
// query block.
// ----------------------------------------------------------------------------
package stt_pkg;

  // array size and derived widths
  localparam int MAX_ELEMENTS = 1024;
  localparam int LEAF_W       = $clog2(MAX_ELEMENTS);
  localparam int ADDR_W       = LEAF_W + 1;          // node index 1 .. 2*MAX-1
  localparam int NODE_DEPTH   = 2 * MAX_ELEMENTS;
  localparam int BOUND_W      = ADDR_W + 1;          // query bound reaches 2*MAX

  // fixed field widths
  localparam int VAL_W = 31;
  localparam int POS_W = 10;
  localparam int LEN_W = 11;
  localparam int SUM_W = 32;
  localparam int EXT_W = (LEN_W > ADDR_W) ? LEN_W : ADDR_W;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

  // operation codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef logic [VAL_W-1:0] val_t;

  typedef struct packed {
    val_t hi;
    val_t lo;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef struct packed {
    val_t             largest;
    val_t             second_largest;
    logic [SUM_W-1:0] pair_sum;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_LEAF,
    ST_WR_READ,
    ST_WR_MERGE,
    ST_Q_LEFT,
    ST_Q_RIGHT,
    ST_Q_DONE
  } state_t;

  // top two of the four values held by two sorted pairs
  function automatic node_t node_merge(node_t a, node_t b);
    node_t m;
    if (a.hi >= b.hi) begin
      m.hi = a.hi;
      m.lo = (a.lo >= b.hi) ? a.lo : b.hi;
    end else begin
      m.hi = b.hi;
      m.lo = (a.hi >= b.lo) ? a.hi : b.lo;
    end
    return m;
  endfunction

endpackage

// File: rtl/stt_if.sv
// ----------------------------------------------------------------------------
// stt_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface stt_req_if
  import stt_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             func;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] range_end;
  val_t             value;

  modport source (output valid, func, position, range_end, value, input ready);
  modport sink   (input valid, func, position, range_end, value, output ready);
endinterface

interface stt_rsp_if
  import stt_pkg::*;
;
  logic             valid;
  logic             ready;
  val_t             largest;
  val_t             second_largest;
  logic [SUM_W-1:0] pair_sum;

  modport source (output valid, largest, second_largest, pair_sum, input ready);
  modport sink   (input valid, largest, second_largest, pair_sum, output ready);
endinterface

// File: rtl/stt_ram.sv
// ----------------------------------------------------------------------------
// stt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/stt_engine.sv
// ----------------------------------------------------------------------------
// stt_engine
// Sequencer for the tree memory: clearing pass, leaf update with ancestor
// recompute, and range query walk with top-two accumulation.
// ----------------------------------------------------------------------------
module stt_engine
  import stt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  stt_req_if.sink           request,
  input  logic [LEN_W-1:0]  length_in_use,
  output result_t           res,
  output logic              res_valid,
  input  logic              res_ready,
  output logic              mem_wr_en,
  output logic [ADDR_W-1:0] mem_wr_addr,
  output node_t             mem_wr_data,
  output logic              mem_rd_en,
  output logic [ADDR_W-1:0] mem_rd_addr,
  input  node_t             mem_rd_data
);

  state_t state;
  state_t state_next;

  logic [ADDR_W-1:0]  clr_cnt;
  logic [ADDR_W-1:0]  cur_idx;
  node_t              cur;
  node_t              acc;
  logic [BOUND_W-1:0] lo_bound;
  logic [BOUND_W-1:0] hi_bound;
  logic               rd_pend;

  logic               in_ready;
  logic               q_rd;
  logic               accept;
  node_t              merged;
  logic [EXT_W-1:0]   len_eff;
  logic [EXT_W-1:0]   last;
  logic [EXT_W-1:0]   pos_ext;
  logic [EXT_W-1:0]   end_ext;
  logic               write_ok;
  logic               query_empty;
  logic [ADDR_W-1:0]  leaf_idx;
  logic [BOUND_W-1:0] hi_dec;
  logic               walk_on;

  assign request.ready = in_ready;
  assign accept        = request.valid && in_ready;

  // request decode
  always_comb begin
    len_eff = (EXT_W'(length_in_use) < EXT_W'(MAX_ELEMENTS)) ?
              EXT_W'(length_in_use) : EXT_W'(MAX_ELEMENTS);
    pos_ext = EXT_W'(request.position);
    end_ext = EXT_W'(request.range_end);
    last    = (end_ext < len_eff - EXT_W'(1)) ? end_ext : len_eff - EXT_W'(1);
    write_ok    = pos_ext < len_eff;
    query_empty = (len_eff == '0) || (pos_ext > last);
    leaf_idx    = ADDR_W'(MAX_ELEMENTS) + ADDR_W'(request.position);
  end

  assign merged  = node_merge(cur, mem_rd_data);
  assign hi_dec  = hi_bound - BOUND_W'(1);
  assign walk_on = lo_bound < hi_bound;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (request.func == FUNC_QUERY) state_next = ST_Q_LEFT;
          else if (write_ok)              state_next = ST_WR_LEAF;
        end
      end
      ST_WR_LEAF:  state_next = ST_WR_READ;
      ST_WR_READ: begin
        state_next = (cur_idx == ADDR_W'(1)) ? ST_IDLE : ST_WR_MERGE;
      end
      ST_WR_MERGE: state_next = ST_WR_READ;
      ST_Q_LEFT: begin
        state_next = walk_on ? ST_Q_RIGHT : ST_Q_DONE;
      end
      ST_Q_RIGHT:  state_next = ST_Q_LEFT;
      ST_Q_DONE: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default:     state_next = ST_CLEAR;
    endcase
  end

  // memory control and handshake outputs
  always_comb begin
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    q_rd        = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = '0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_cnt;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_WR_LEAF: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = cur_idx;
        mem_wr_data = cur;
      end
      ST_WR_READ: begin
        if (cur_idx != ADDR_W'(1)) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = cur_idx ^ ADDR_W'(1);
        end
      end
      ST_WR_MERGE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = cur_idx >> 1;
        mem_wr_data = merged;
      end
      ST_Q_LEFT: begin
        if (walk_on && lo_bound[0]) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = lo_bound[ADDR_W-1:0];
          q_rd        = 1'b1;
        end
      end
      ST_Q_RIGHT: begin
        if (hi_bound[0]) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = hi_dec[ADDR_W-1:0];
          q_rd        = 1'b1;
        end
      end
      ST_Q_DONE: begin
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  // clearing counter and read-pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= q_rd;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          acc     <= '0;
          cur     <= '{hi: request.value, lo: '0};
          cur_idx <= leaf_idx;
          if (query_empty) begin
            lo_bound <= '0;
            hi_bound <= '0;
          end else begin
            lo_bound <= BOUND_W'(pos_ext) + BOUND_W'(MAX_ELEMENTS);
            hi_bound <= BOUND_W'(last) + BOUND_W'(MAX_ELEMENTS) + BOUND_W'(1);
          end
        end
      end
      ST_WR_MERGE: begin
        cur     <= merged;
        cur_idx <= cur_idx >> 1;
      end
      ST_Q_LEFT: begin
        if (walk_on && lo_bound[0]) lo_bound <= lo_bound + BOUND_W'(1);
      end
      ST_Q_RIGHT: begin
        // an odd upper bound steps down first, which halves to the same value
        hi_bound <= hi_bound >> 1;
        lo_bound <= lo_bound >> 1;
      end
      default: ;
    endcase
    // fold a node read by the query walk into the running pair
    if (rd_pend) acc <= node_merge(acc, mem_rd_data);
  end

  // result payload
  always_comb begin
    res.largest        = acc.hi;
    res.second_largest = acc.lo;
    res.pair_sum       = SUM_W'(acc.hi) + SUM_W'(acc.lo);
  end

endmodule

// File: rtl/segment_tree_top_two_range_query.sv
// ----------------------------------------------------------------------------
// segment_tree_top_two_range_query
// Top level: length register, tree memory, sequencer and result register.
// ----------------------------------------------------------------------------
// The block keeps a segment tree of 2048 nodes in one RAM with a registered
// read, each node holding the top two values of its span. After reset a
// clearing pass writes zero to every node, one per cycle, and the request
// channel stays not ready until that pass ends; configuration writes are taken
// at any time. Items are handled one at a time. A write stores the leaf,
// then for each tree level reads the sibling and writes the parent; a
// dropped write is taken and discarded in the idle state. A query walk takes
// at most 11 steps, each reading at most a left node and then a right node
// through the single RAM read port, and then offers the result. Results wait in an
// output register, so the next request is taken while a result is unclaimed.
module segment_tree_top_two_range_query
  import stt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  stt_req_if.sink          request,
  stt_rsp_if.source        result
);

  logic [LEN_W-1:0]  length_in_use;
  result_t           res;
  logic              res_valid;
  logic              res_ready;
  logic              out_valid;
  result_t           out_data;
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  node_t             mem_wr_data;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  node_t             mem_rd_data;

  // length register
  always_ff @(posedge clk) begin
    if (rst) begin
      length_in_use <= LEN_RESET;
    end else if (cfg_wr_en) begin
      length_in_use <= cfg_wr_data;
    end
  end

  stt_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  stt_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .request       (request),
    .length_in_use (length_in_use),
    .res           (res),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_en     (mem_rd_en),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data)
  );

  // output register
  assign res_ready = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= res;
    end
  end

  assign result.valid          = out_valid;
  assign result.largest        = out_data.largest;
  assign result.second_largest = out_data.second_largest;
  assign result.pair_sum       = out_data.pair_sum;

endmodule

// File: rtl/stt_checker.sv
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks for the top-two range query block, bound to the top level.
// ----------------------------------------------------------------------------
module stt_checker
  import stt_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input val_t             rsp_largest,
  input val_t             rsp_second,
  input logic [SUM_W-1:0] rsp_sum
);

  // a result beat stays offered until taken
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result beat dropped before it was taken");

  // the clearing pass keeps requests out right after reset
  assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request taken during clearing pass");

  // the pair stays ordered
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_second <= rsp_largest)
    else $error("second largest above largest");

  // the sum matches the pair
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_sum == SUM_W'(rsp_largest) + SUM_W'(rsp_second))
    else $error("pair sum mismatch");

endmodule

bind segment_tree_top_two_range_query stt_checker u_stt_checker (
  .clk         (clk),
  .rst         (rst),
  .req_ready   (request.ready),
  .rsp_valid   (result.valid),
  .rsp_ready   (result.ready),
  .rsp_largest (result.largest),
  .rsp_second  (result.second_largest),
  .rsp_sum     (result.pair_sum)
);

// File: sim/tb_segment_tree_top_two_range_query.sv
// ----------------------------------------------------------------------------
// tb_segment_tree_top_two_range_query
// Self-checking bench for the top-two range query block: element writes and
// range queries go in through a valid/ready driver, a software copy of the
// segment tree predicts each query answer, and a monitor checks every result
// beat against the oldest prediction. The array length is changed between
// phases, and the sender and receiver idle at different rates.
// ----------------------------------------------------------------------------
module tb_segment_tree_top_two_range_query;
  import stt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic             func;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] range_end;
    val_t             value;
  } tree_op_t;

  localparam val_t VAL_MAX      = '1;
  localparam int   SETTLE_TICKS = 40;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;

  stt_req_if req_ch ();
  stt_rsp_if rsp_ch ();

  segment_tree_top_two_range_query dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .request     (req_ch),
    .result      (rsp_ch)
  );

  // bench-side copy of the tree and the length register
  node_t            tree_copy [NODE_DEPTH];
  logic [LEN_W-1:0] length_copy;

  tree_op_t pending_ops [$];
  result_t  expected_answers [$];
  tree_op_t op_on_bus;

  int unsigned pushed_ops;
  int unsigned accepted_ops;
  int unsigned fail_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned window_base;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #3200000;
    $display("simulation failed");
    $finish;
  end

  // insert one value into a sorted top-two pair
  function automatic node_t take_value(node_t acc, val_t v);
    node_t n;
    n = acc;
    if (v > n.hi) begin
      n.lo = n.hi;
      n.hi = v;
    end else if (v > n.lo) begin
      n.lo = v;
    end
    return n;
  endfunction

  function automatic node_t absorb_node(node_t acc, node_t x);
    return take_value(take_value(acc, x.hi), x.lo);
  endfunction

  // update the tree copy for one accepted beat, queue the answer of a query
  function automatic void predict_tree_op(tree_op_t op);
    int unsigned span;
    int unsigned idx;
    int unsigned upto;
    int unsigned lft;
    int unsigned rgt;
    node_t       acc;
    result_t     ans;
    span = (length_copy < MAX_ELEMENTS) ? length_copy : MAX_ELEMENTS;
    if (op.func == FUNC_WRITE) begin
      // writes past the length in use are dropped
      if (op.position < span) begin
        idx = op.position + MAX_ELEMENTS;
        tree_copy[idx].hi = op.value;
        tree_copy[idx].lo = '0;
        idx = idx >> 1;
        while (idx >= 1) begin
          tree_copy[idx] = absorb_node(tree_copy[2*idx], tree_copy[2*idx+1]);
          idx = idx >> 1;
        end
      end
    end else begin
      acc = '0;
      if (span > 0) begin
        upto = (op.range_end < span - 1) ? op.range_end : span - 1;
        if (op.position <= upto) begin
          lft = op.position + MAX_ELEMENTS;
          rgt = upto + 1 + MAX_ELEMENTS;
          while (lft < rgt) begin
            if (lft[0]) begin
              acc = absorb_node(acc, tree_copy[lft]);
              lft = lft + 1;
            end
            if (rgt[0]) begin
              rgt = rgt - 1;
              acc = absorb_node(acc, tree_copy[rgt]);
            end
            lft = lft >> 1;
            rgt = rgt >> 1;
          end
        end
      end
      ans.largest        = acc.hi;
      ans.second_largest = acc.lo;
      ans.pair_sum       = SUM_W'(acc.hi) + SUM_W'(acc.lo);
      expected_answers.push_back(ans);
    end
  endfunction

  // request driver fed from the pending queue
  always @(posedge clk) begin
    logic fire;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      fire = req_ch.valid && req_ch.ready;
      if (fire) begin
        predict_tree_op(op_on_bus);
        accepted_ops = accepted_ops + 1;
      end
      if (!req_ch.valid || fire) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          op_on_bus          = pending_ops.pop_front();
          req_ch.func       <= op_on_bus.func;
          req_ch.position   <= op_on_bus.position;
          req_ch.range_end  <= op_on_bus.range_end;
          req_ch.value      <= op_on_bus.value;
          req_ch.valid      <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected result beat largest=%0d second=%0d sum=%0d",
                   $time, rsp_ch.largest, rsp_ch.second_largest, rsp_ch.pair_sum);
          fail_count = fail_count + 1;
        end else begin
          want = expected_answers.pop_front();
          if (rsp_ch.largest !== want.largest) begin
            $display("%0t: largest expected %0d actual %0d",
                     $time, want.largest, rsp_ch.largest);
            fail_count = fail_count + 1;
          end
          if (rsp_ch.second_largest !== want.second_largest) begin
            $display("%0t: second_largest expected %0d actual %0d",
                     $time, want.second_largest, rsp_ch.second_largest);
            fail_count = fail_count + 1;
          end
          if (rsp_ch.pair_sum !== want.pair_sum) begin
            $display("%0t: pair_sum expected %0d actual %0d",
                     $time, want.pair_sum, rsp_ch.pair_sum);
            fail_count = fail_count + 1;
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic add_op(logic func, int unsigned pos, int unsigned upto, val_t v);
    tree_op_t op;
    op.func      = func;
    op.position  = POS_W'(pos);
    op.range_end = POS_W'(upto);
    op.value     = v;
    pending_ops.push_back(op);
    pushed_ops = pushed_ops + 1;
  endtask

  // mostly writes and queries in a narrow window so queries see real content
  task automatic add_random_op();
    tree_op_t    op;
    int unsigned pick;
    int unsigned stop;
    op.func = ($urandom_range(99) < 50) ? FUNC_QUERY : FUNC_WRITE;
    if ($urandom_range(99) < 70)
      op.position = POS_W'(window_base + $urandom_range(31));
    else
      op.position = POS_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 75) begin
      stop = op.position + $urandom_range(48);
      op.range_end = (stop > MAX_ELEMENTS - 1) ? POS_W'(MAX_ELEMENTS - 1) : POS_W'(stop);
    end else if (pick < 90) begin
      op.range_end = POS_W'($urandom);
    end else begin
      // inverted range
      op.range_end = op.position - POS_W'($urandom_range(1, 8));
    end
    pick = $urandom_range(99);
    if (pick < 40)
      op.value = val_t'($urandom_range(7));
    else if (pick < 50)
      op.value = VAL_MAX;
    else if (pick < 55)
      op.value = '0;
    else
      op.value = val_t'($urandom);
    pending_ops.push_back(op);
    pushed_ops = pushed_ops + 1;
  endtask

  task automatic add_random_ops(int unsigned n);
    repeat (n) add_random_op();
  endtask

  // wait until every beat is taken and answered, then let an accepted write finish its tree update
  task automatic wait_drained();
    while (accepted_ops != pushed_ops || expected_answers.size() != 0)
      @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // new length and idling mix, written only while the block is idle
  task automatic start_phase(int unsigned len, int unsigned send_pct,
                             int unsigned recv_pct, int unsigned base);
    wait_drained();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= LEN_W'(len);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    length_copy    = LEN_W'(len);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    window_base    = base;
  endtask

  // main sequence
  initial begin
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    req_ch.valid     = 1'b0;
    req_ch.func      = FUNC_WRITE;
    req_ch.position  = '0;
    req_ch.range_end = '0;
    req_ch.value     = '0;
    rsp_ch.ready     = 1'b0;
    pushed_ops       = 0;
    accepted_ops     = 0;
    fail_count       = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    window_base      = 0;
    length_copy      = LEN_RESET;
    foreach (tree_copy[i]) tree_copy[i] = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset length: empty tree, extremes, duplicates,
    // single element, inverted ranges, overwrites
    add_op(FUNC_QUERY, 0, 1023, VAL_MAX);
    add_op(FUNC_WRITE, 0, 1023, VAL_MAX);
    add_op(FUNC_WRITE, 1023, 0, VAL_MAX);
    add_op(FUNC_QUERY, 0, 1023, '0);
    add_op(FUNC_QUERY, 0, 0, '0);
    add_op(FUNC_QUERY, 1023, 1023, '0);
    add_op(FUNC_WRITE, 5, 0, 7);
    add_op(FUNC_WRITE, 6, 0, 7);
    add_op(FUNC_QUERY, 5, 6, '0);
    add_op(FUNC_QUERY, 6, 5, '0);
    add_op(FUNC_QUERY, 1, 1022, '0);
    add_op(FUNC_WRITE, 512, 0, 1);
    add_op(FUNC_QUERY, 7, 1022, '0);
    add_op(FUNC_WRITE, 0, 0, '0);
    add_op(FUNC_WRITE, 1023, 0, 3);
    add_op(FUNC_QUERY, 0, 1023, '0);
    add_op(FUNC_WRITE, 6, 0, val_t'(32'h5555_5555));
    add_op(FUNC_WRITE, 5, 0, val_t'(32'h2AAA_AAAA));
    add_op(FUNC_QUERY, 4, 7, '0);
    add_op(FUNC_QUERY, 1023, 0, '0);
    add_op(FUNC_QUERY, 0, 1023, '0);
    window_base = 0;
    add_random_ops(150);

    // length one, sender idling: clipping and dropped writes
    start_phase(1, 54, 0, 0);
    add_op(FUNC_QUERY, 0, 1023, '0);
    add_op(FUNC_WRITE, 1, 0, 9);
    add_op(FUNC_QUERY, 0, 1, '0);
    add_random_ops(60);

    // largest length code, receiver stalling: old leaves come back
    start_phase(2047, 0, 54, 1000);
    add_op(FUNC_QUERY, 0, 1023, '0);
    add_random_ops(120);

    // length zero: every write dropped, every query empty
    start_phase(0, 7, 7, 0);
    add_op(FUNC_QUERY, 0, 0, '0);
    add_op(FUNC_WRITE, 0, 0, 11);
    add_op(FUNC_QUERY, 0, 1023, '0);
    add_random_ops(30);

    // short length, both sides idling, window across the boundary
    start_phase(37, 7, 7, 20);
    add_op(FUNC_WRITE, 36, 0, 100);
    add_op(FUNC_WRITE, 37, 0, 200);
    add_op(FUNC_QUERY, 30, 1023, '0);
    add_random_ops(90);

    // full length again, no idling, with a pause until all answers are back
    start_phase(1024, 0, 0, 500);
    add_random_ops(50);
    wait_drained();
    add_random_ops(50);

    wait_drained();
    if (fail_count == 0 && expected_answers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
